// File: src/epoch_to_calendar_date_macros.svh
// assertion macros for the epoch to calendar date block
// no dependencies; included by the top level
`ifndef EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define E2C_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define E2C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define E2C_ASSERT(lbl, clk, rstn, prop, msg)
`define E2C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: src/e2c_pkg.sv
// types, constants and the divide-by-sixty helper for the epoch to calendar date block
// no dependencies
package e2c_pkg;

    // seconds per day is 2^7 * 675
    localparam int unsigned DAY_SHIFT = 7;
    localparam logic [9:0]  DAY_DIV   = 10'd675;
    localparam int unsigned DAY_RECIP_SHIFT = 35;
    localparam logic [25:0] DAY_RECIP = 26'((64'd1 << DAY_RECIP_SHIFT) / 64'd675);

    // x / 60 = (x / 4) / 15
    localparam int unsigned SIXTY_RECIP_SHIFT = 20;
    localparam logic [16:0] SIXTY_RECIP = 17'((64'd1 << SIXTY_RECIP_SHIFT) / 64'd15);
    localparam logic [16:0] SIXTY       = 17'd60;

    // four-year cycles counted from 1968-01-01
    localparam logic [15:0] QUAD_DAYS  = 16'd1461;
    localparam int unsigned QUAD_RECIP_SHIFT = 26;
    localparam logic [15:0] QUAD_RECIP = 16'((64'd1 << QUAD_RECIP_SHIFT) / 64'd1461);
    localparam logic [15:0] EPOCH_BIAS = 16'd731;
    // day index of 2100-03-01; 2100 has no leap day
    localparam logic [15:0] SKIP_LEAP_DAY = 16'd47541;
    localparam logic [11:0] BASE_YEAR  = 12'd1968;

    localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};
    localparam logic [8:0]  MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

    localparam int unsigned DATE_STAGES = 6;
    localparam int unsigned TOD_PAD     = DATE_STAGES - 1;

    typedef struct packed {
        logic [10:0] q;
        logic [5:0]  r;
    } div60_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    function automatic div60_t div60(input logic [16:0] x);
        logic [31:0] prod;
        logic [10:0] q;
        logic [16:0] r;
        div60_t      res;
        prod = {17'd0, x[16:2]} * {15'd0, SIXTY_RECIP};
        q    = prod[30:20];
        r    = x - ({q, 6'd0} - {4'd0, q, 2'd0});
        if (r >= SIXTY)
        begin
            q = q + 11'd1;
            r = r - SIXTY;
        end
        res.q = q;
        res.r = r[5:0];
        return res;
    endfunction

endpackage

// File: src/e2c_tod.sv
// time of day split: seconds of the day into hour, minute and second
// depends on e2c_pkg; latency matches the date path
module e2c_tod
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] sod,
    output tod_t        tod
);

    logic [10:0] mins_reg;
    logic [5:0]  sec_reg;
    tod_t        tod_reg [TOD_PAD];
    div60_t      sod_div;
    div60_t      min_div;
    tod_t        tod_next;

    always_comb
    begin
        sod_div         = div60(sod);
        min_div         = div60({6'd0, mins_reg});
        tod_next.hour   = min_div.q[4:0];
        tod_next.minute = min_div.r;
        tod_next.second = sec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mins_reg   <= sod_div.q;
            sec_reg    <= sod_div.r;
            tod_reg[0] <= tod_next;
            for (int i = 1; i < TOD_PAD; i++)
            begin
                tod_reg[i] <= tod_reg[i-1];
            end
        end
    end

    assign tod = tod_reg[TOD_PAD-1];

endmodule

// File: src/e2c_date.sv
// day count since 1970 into year, month and day, six register stages
// depends on e2c_pkg
module e2c_date
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] days,
    output date_t       date
);

    logic [15:0] dd_reg;
    logic [15:0] dd_next;
    logic [15:0] dd2_reg;
    logic [31:0] qprod_reg;
    logic [5:0]  cyc_reg;
    logic [5:0]  cyc_next;
    logic [10:0] rem_reg;
    logic [15:0] rem_full;
    logic [11:0] year4_reg;
    logic [11:0] year4_next;
    logic [8:0]  doy4_reg;
    logic [8:0]  doy4_next;
    logic        leap4_reg;
    logic [1:0]  yoff;
    logic [10:0] doy_wide;
    logic [11:0] year5_reg;
    logic [3:0]  mon5_reg;
    logic [3:0]  mon5_next;
    logic [8:0]  mst5_reg;
    logic [8:0]  mst5_next;
    logic [8:0]  doy5_reg;
    logic [8:0]  st;
    logic [8:0]  day_full;
    date_t       date_reg;
    date_t       date_next;

    // shift to a leap-aligned base and insert a phantom leap day for 2100
    assign dd_next = days + EPOCH_BIAS + {15'd0, days >= SKIP_LEAP_DAY};

    always_comb
    begin
        cyc_next = qprod_reg[31:26];
        rem_full = dd2_reg - ({10'd0, cyc_next} * QUAD_DAYS);
        if (rem_full >= QUAD_DAYS)
        begin
            cyc_next = cyc_next + 6'd1;
            rem_full = rem_full - QUAD_DAYS;
        end
    end

    always_comb
    begin
        if (rem_reg >= YEAR_START[3])
            yoff = 2'd3;
        else if (rem_reg >= YEAR_START[2])
            yoff = 2'd2;
        else if (rem_reg >= YEAR_START[1])
            yoff = 2'd1;
        else
            yoff = 2'd0;
        doy_wide   = rem_reg - YEAR_START[yoff];
        doy4_next  = doy_wide[8:0];
        year4_next = BASE_YEAR + {4'd0, cyc_reg, 2'd0} + {10'd0, yoff};
    end

    always_comb
    begin
        mon5_next = 4'd1;
        mst5_next = 9'd0;
        st        = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            st = MONTH_START[i] + {8'd0, leap4_reg && (i >= 2)};
            if (doy4_reg >= st)
            begin
                mon5_next = 4'(i + 1);
                mst5_next = st;
            end
        end
    end

    always_comb
    begin
        day_full        = doy5_reg - mst5_reg + 9'd1;
        date_next.year  = year5_reg;
        date_next.month = mon5_reg;
        date_next.day   = day_full[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg    <= dd_next;
            qprod_reg <= {16'd0, dd_reg} * {16'd0, QUAD_RECIP};
            dd2_reg   <= dd_reg;
            cyc_reg   <= cyc_next;
            rem_reg   <= rem_full[10:0];
            year4_reg <= year4_next;
            doy4_reg  <= doy4_next;
            leap4_reg <= (yoff == 2'd0);
            year5_reg <= year4_reg;
            mon5_reg  <= mon5_next;
            mst5_reg  <= mst5_next;
            doy5_reg  <= doy4_reg;
            date_reg  <= date_next;
        end
    end

    assign date = date_reg;

endmodule

// File: src/epoch_to_calendar_date.sv
// epoch to calendar date: Unix seconds into UTC date and time of day
// depends on e2c_pkg, e2c_tod, e2c_date and epoch_to_calendar_date_macros.svh
//
// input channel: in_valid / in_ready carry one beat of epoch_seconds
// output channel: out_valid / out_ready carry one beat of valid_res, year,
//   month, day, hour, minute and second for each input beat, in order
// pipeline of 9 register stages: epoch and day product, days and second of day,
//   the date and time-of-day stages, then the output registers
// throughput: one beat per cycle unless the output stalls; the reciprocal
//   multipliers of the day and four-year splits each sit in a stage of their own
// epoch zero yields valid_res low with every other field zero
// when out_ready is low with a beat waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated
// reset clears every stage valid bit; the block takes a beat right after
//   reset is released
`include "epoch_to_calendar_date_macros.svh"
module epoch_to_calendar_date
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    localparam int unsigned PIPE_STAGES = DATE_STAGES + 3;

    logic                   adv;
    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] zero_reg;
    logic [50:0]            prod1_reg;
    logic [31:0]            epoch1_reg;
    logic [24:0]            x1;
    logic [15:0]            q1;
    logic [24:0]            r1;
    logic [15:0]            days_reg;
    logic [16:0]            sod_reg;
    tod_t                   tod;
    date_t                  date;
    logic                   valid_res_reg;
    logic [11:0]            year_reg;
    logic [3:0]             month_reg;
    logic [4:0]             day_reg;
    logic [4:0]             hour_reg;
    logic [5:0]             minute_reg;
    logic [5:0]             second_reg;
    logic                   zero_last;

    assign adv       = !v_reg[PIPE_STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign zero_last = zero_reg[PIPE_STAGES-2];

    // day split: quotient estimate is exact or one short
    always_comb
    begin
        x1 = epoch1_reg[31:DAY_SHIFT];
        q1 = prod1_reg[50:DAY_RECIP_SHIFT];
        r1 = x1 - ({9'd0, q1} * {15'd0, DAY_DIV});
        if (r1 >= {15'd0, DAY_DIV})
        begin
            q1 = q1 + 16'd1;
            r1 = r1 - {15'd0, DAY_DIV};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[PIPE_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg      <= {zero_reg[PIPE_STAGES-2:0], epoch_seconds == 32'd0};
            epoch1_reg    <= epoch_seconds;
            prod1_reg     <= {26'd0, epoch_seconds[31:DAY_SHIFT]} * {25'd0, DAY_RECIP};
            days_reg      <= q1;
            sod_reg       <= {r1[9:0], epoch1_reg[DAY_SHIFT-1:0]};
            valid_res_reg <= !zero_last;
            year_reg      <= zero_last ? 12'd0 : date.year;
            month_reg     <= zero_last ? 4'd0 : date.month;
            day_reg       <= zero_last ? 5'd0 : date.day;
            hour_reg      <= zero_last ? 5'd0 : tod.hour;
            minute_reg    <= zero_last ? 6'd0 : tod.minute;
            second_reg    <= zero_last ? 6'd0 : tod.second;
        end
    end

    e2c_tod u_tod
    (
        .clk (clk),
        .en  (adv),
        .sod (sod_reg),
        .tod (tod)
    );

    e2c_date u_date
    (
        .clk  (clk),
        .en   (adv),
        .days (days_reg),
        .date (date)
    );

    assign out_valid = v_reg[PIPE_STAGES-1];
    assign valid_res = valid_res_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign hour      = hour_reg;
    assign minute    = minute_reg;
    assign second    = second_reg;

    `E2C_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, v_reg == $past(v_reg), "pipeline moved during stall")
    `E2C_ASSERT(a_zero_fields, clk, rst_n, (out_valid && !valid_res) |-> (year == 12'd0 && month == 4'd0 && day == 5'd0 && hour == 5'd0 && minute == 6'd0 && second == 6'd0), "invalid beat has nonzero fields")
    `E2C_ASSERT(a_date_range, clk, rst_n, (out_valid && valid_res) |-> (year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1 && month <= 4'd12 && day >= 5'd1), "date out of range")
    `E2C_ASSERT(a_time_range, clk, rst_n, out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59), "time of day out of range")

endmodule
